// ===== sv/lkc_pkg.sv =====
// Shared constants, codes and control types for the keyed LRU cache.
`timescale 1ns / 1ps

package lkc_pkg;

  localparam int DEPTH_DEF        = 16;
  localparam int KEY_WIDTH_DEF    = 32;
  localparam int HANDLE_WIDTH_DEF = 32;

  localparam int CAP_W    = 5;
  localparam int LEN_W    = 20;
  localparam int TYPE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  localparam logic [STATUS_W-1:0] ST_GET_HIT      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_GET_MISS     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_PUT_INSERTED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_PUT_UPDATED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_PUT_REJECTED = 3'd4;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic look;    // capture key compare
    logic apply;   // perform the reorder this cycle
    logic hit;     // hit entry moves to the front
    logic insert;  // new entry enters at the front
    logic evict;   // least recent entry is dropped
  } ctrl_t;

endpackage

// ===== sv/lru_keyed_cache.sv =====
// Top level of the fully associative keyed LRU cache.
//
// Input channel: in_valid / in_stall carry one request per transaction:
// func (get or put), key_tag, and for a put the content handle, length and
// type. Output channel: out_valid / out_stall carry one result transaction
// per request with status, hit payload, eviction report and entry count.
// Entries sit in a row of slot cells in recency order, slot 0 most recent.
// The request is latched when it is accepted; every cell's key compare is then
// registered, and once the output register is free the row shifts by one slot
// toward the back over the moving region and the result is registered.
// A new request is accepted only once the previous result has been registered.
// A new request is taken while an earlier result still waits on the output.
// If the receiver stalls, the next request waits in its reorder step until
// the output register is free, and in_stall stays high meanwhile.
// Reset empties the store, clears both valids and sets capacity to 16.
// A write on cfg_wr_en sets capacity and empties the store; the user must issue
// it only while no request is in flight, as the block does not enforce this.
`timescale 1ns / 1ps

module lru_keyed_cache #(
  parameter int DEPTH        = lkc_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH    = lkc_pkg::KEY_WIDTH_DEF,
  parameter int HANDLE_WIDTH = lkc_pkg::HANDLE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [lkc_pkg::CAP_W-1:0]     cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          func,
  input  logic [KEY_WIDTH-1:0]          key_tag,
  input  logic [HANDLE_WIDTH-1:0]       content_handle,
  input  logic [lkc_pkg::LEN_W-1:0]     content_bytes,
  input  logic [lkc_pkg::TYPE_W-1:0]    content_type_id,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lkc_pkg::STATUS_W-1:0]  status,
  output logic [HANDLE_WIDTH-1:0]       out_handle,
  output logic [lkc_pkg::LEN_W-1:0]     out_length,
  output logic [lkc_pkg::TYPE_W-1:0]    out_type,
  output logic                          evicted,
  output logic [KEY_WIDTH-1:0]          evicted_key,
  output logic [lkc_pkg::COUNT_W-1:0]   entry_count
);

  localparam int PW    = HANDLE_WIDTH + lkc_pkg::LEN_W + lkc_pkg::TYPE_W;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > lkc_pkg::CAP_W) ? CNT_W : lkc_pkg::CAP_W;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_LOOK  = 2'd1;
  localparam logic [1:0] PH_APPLY = 2'd2;

  logic [1:0]                 phase;
  logic [lkc_pkg::CAP_W-1:0]  capacity;
  logic [CNT_W-1:0]           held_count;

  logic                       req_func;
  logic [KEY_WIDTH-1:0]       req_key;
  logic [PW-1:0]              req_payload;
  logic                       req_null;

  lkc_pkg::ctrl_t             ctrl;
  logic                       out_free;
  logic                       hit;
  logic                       is_put;
  logic                       evict_now;
  logic [CMP_W-1:0]           cap_eff;
  logic [CMP_W-1:0]           cap_ext;
  logic [KEY_WIDTH-1:0]       front_key;
  logic [PW-1:0]              front_payload;
  logic [PW-1:0]              hit_payload;
  logic [KEY_WIDTH-1:0]       last_key;
  logic [CNT_W-1:0]           held_count_next;
  logic [lkc_pkg::STATUS_W-1:0] status_next;

  logic [DEPTH-1:0]           c_valid;
  logic [KEY_WIDTH-1:0]       c_key [DEPTH];
  logic [PW-1:0]              c_payload [DEPTH];
  logic [DEPTH:0]             c_hit_after;
  logic [PW-1:0]              c_rd_hit [DEPTH+1];
  logic [KEY_WIDTH-1:0]       c_rd_evk [DEPTH+1];

  assign in_stall = (phase != PH_IDLE);
  assign out_free = !(out_valid && out_stall);

  assign hit_payload = c_rd_hit[DEPTH];
  assign last_key    = c_rd_evk[DEPTH];
  assign hit         = c_hit_after[0];
  assign is_put      = (req_func == lkc_pkg::FUNC_PUT);

  always_comb begin
    cap_ext = CMP_W'(capacity);
    if (capacity == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_ext > CMP_W'(DEPTH)) begin
      cap_eff = CMP_W'(DEPTH);
    end else begin
      cap_eff = cap_ext;
    end
  end

  assign evict_now = ctrl.insert && (CMP_W'(held_count) >= cap_eff);

  always_comb begin
    ctrl        = '0;
    ctrl.look   = (phase == PH_LOOK);
    ctrl.apply  = (phase == PH_APPLY) && out_free;
    ctrl.hit    = hit && !(is_put && req_null);
    ctrl.insert = is_put && !req_null && !hit;
    ctrl.evict  = evict_now;
  end

  // get hit keeps its own payload, put writes the new one
  assign front_key     = req_key;
  assign front_payload = is_put ? req_payload : hit_payload;

  always_comb begin
    held_count_next = held_count;
    if (ctrl.insert && !evict_now) begin
      held_count_next = held_count + CNT_W'(1);
    end
  end

  always_comb begin
    if (!is_put) begin
      status_next = hit ? lkc_pkg::ST_GET_HIT : lkc_pkg::ST_GET_MISS;
    end else if (req_null) begin
      status_next = lkc_pkg::ST_PUT_REJECTED;
    end else if (hit) begin
      status_next = lkc_pkg::ST_PUT_UPDATED;
    end else begin
      status_next = lkc_pkg::ST_PUT_INSERTED;
    end
  end

  assign c_hit_after[DEPTH] = 1'b0;
  assign c_rd_hit[0]        = '0;
  assign c_rd_evk[0]        = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 p_valid;
    logic [KEY_WIDTH-1:0] p_key;
    logic [PW-1:0]        p_payload;
    logic                 n_valid;

    if (i == 0) begin : g_front
      assign p_valid   = 1'b1;
      assign p_key     = front_key;
      assign p_payload = front_payload;
    end else begin : g_mid
      assign p_valid   = c_valid[i-1];
      assign p_key     = c_key[i-1];
      assign p_payload = c_payload[i-1];
    end

    if (i == DEPTH - 1) begin : g_back
      assign n_valid = 1'b0;
    end else begin : g_inner
      assign n_valid = c_valid[i+1];
    end

    lkc_cell #(
      .KEY_WIDTH     (KEY_WIDTH),
      .PAYLOAD_WIDTH (PW)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .clear         (cfg_wr_en),
      .ctrl          (ctrl),
      .req_key       (req_key),
      .prev_valid    (p_valid),
      .prev_key      (p_key),
      .prev_payload  (p_payload),
      .next_valid    (n_valid),
      .hit_after_in  (c_hit_after[i+1]),
      .hit_after_out (c_hit_after[i]),
      .rd_hit_in     (c_rd_hit[i]),
      .rd_hit_out    (c_rd_hit[i+1]),
      .rd_evk_in     (c_rd_evk[i]),
      .rd_evk_out    (c_rd_evk[i+1]),
      .valid         (c_valid[i]),
      .key           (c_key[i]),
      .payload       (c_payload[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      capacity   <= lkc_pkg::CAP_RESET;
      held_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        capacity   <= cfg_wr_data;
        held_count <= '0;
      end else if (ctrl.apply) begin
        held_count <= held_count_next;
      end

      if (ctrl.apply) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (phase)
        PH_IDLE: begin
          if (in_valid) begin
            phase <= PH_LOOK;
          end
        end
        PH_LOOK: begin
          phase <= PH_APPLY;
        end
        PH_APPLY: begin
          if (out_free) begin
            phase <= PH_IDLE;
          end
        end
        default: begin
          phase <= PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (phase == PH_IDLE && in_valid) begin
      req_func    <= func;
      req_key     <= key_tag;
      req_payload <= {content_handle, content_bytes, content_type_id};
      req_null    <= (content_handle == '0);
    end
    if (ctrl.apply) begin
      status      <= status_next;
      evicted     <= evict_now;
      evicted_key <= evict_now ? last_key : '0;
      entry_count <= lkc_pkg::COUNT_W'(held_count_next);
      if (!is_put && hit) begin
        {out_handle, out_length, out_type} <= hit_payload;
      end else begin
        {out_handle, out_length, out_type} <= '0;
      end
    end
  end

endmodule

// ===== sv/lkc_cell.sv =====
// One cache slot: key, payload, valid, match flag, and neighbor hand-off.
`timescale 1ns / 1ps

module lkc_cell #(
  parameter int KEY_WIDTH     = lkc_pkg::KEY_WIDTH_DEF,
  parameter int PAYLOAD_WIDTH = lkc_pkg::HANDLE_WIDTH_DEF + lkc_pkg::LEN_W + lkc_pkg::TYPE_W
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     clear,
  input  lkc_pkg::ctrl_t           ctrl,
  input  logic [KEY_WIDTH-1:0]     req_key,
  input  logic                     prev_valid,
  input  logic [KEY_WIDTH-1:0]     prev_key,
  input  logic [PAYLOAD_WIDTH-1:0] prev_payload,
  input  logic                     next_valid,
  input  logic                     hit_after_in,
  output logic                     hit_after_out,
  input  logic [PAYLOAD_WIDTH-1:0] rd_hit_in,
  output logic [PAYLOAD_WIDTH-1:0] rd_hit_out,
  input  logic [KEY_WIDTH-1:0]     rd_evk_in,
  output logic [KEY_WIDTH-1:0]     rd_evk_out,
  output logic                     valid,
  output logic [KEY_WIDTH-1:0]     key,
  output logic [PAYLOAD_WIDTH-1:0] payload
);

  logic match;
  logic last;
  logic shift;

  assign hit_after_out = match | hit_after_in;
  assign last          = valid & ~next_valid;

  // take the neighbor's contents when this slot lies in the moving region
  assign shift = ctrl.apply &
                 (ctrl.hit ? hit_after_out
                           : (ctrl.insert & (ctrl.evict ? valid : prev_valid)));

  assign rd_hit_out = rd_hit_in | ({PAYLOAD_WIDTH{match}} & payload);
  assign rd_evk_out = rd_evk_in | ({KEY_WIDTH{last}} & key);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      match <= 1'b0;
    end else begin
      if (clear) begin
        valid <= 1'b0;
      end else if (shift) begin
        valid <= prev_valid;
      end
      if (ctrl.look) begin
        match <= valid && (key == req_key);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      key     <= prev_key;
      payload <= prev_payload;
    end
  end

endmodule

// ===== sv/lkc_checker.sv =====
// Port-level checks for the keyed LRU cache, bound to the top level.
`timescale 1ns / 1ps

module lkc_checker #(
  parameter int KEY_WIDTH    = lkc_pkg::KEY_WIDTH_DEF,
  parameter int HANDLE_WIDTH = lkc_pkg::HANDLE_WIDTH_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [lkc_pkg::STATUS_W-1:0] status,
  input logic [HANDLE_WIDTH-1:0]      out_handle,
  input logic [lkc_pkg::LEN_W-1:0]    out_length,
  input logic [lkc_pkg::TYPE_W-1:0]   out_type,
  input logic                         evicted,
  input logic [KEY_WIDTH-1:0]         evicted_key
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(evicted_key))
    else $error("result changed while stalled");

  a_payload_only_on_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != lkc_pkg::ST_GET_HIT |->
      out_handle == '0 && out_length == '0 && out_type == '0)
    else $error("payload shown on a non-hit result");

  a_evict_on_insert: assert property (@(posedge clk) disable iff (rst)
    out_valid && evicted |-> status == lkc_pkg::ST_PUT_INSERTED)
    else $error("eviction reported on a non-insert result");

  a_evict_key_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !evicted |-> evicted_key == '0)
    else $error("evicted key set without an eviction");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind lru_keyed_cache lkc_checker #(
  .KEY_WIDTH    (KEY_WIDTH),
  .HANDLE_WIDTH (HANDLE_WIDTH)
) u_lkc_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .out_handle  (out_handle),
  .out_length  (out_length),
  .out_type    (out_type),
  .evicted     (evicted),
  .evicted_key (evicted_key)
);

// ===== bench/lru_keyed_cache_test.sv =====
// Self-checking testbench for the keyed LRU cache: directed, random and backpressure tests.
`timescale 1ns / 1ps

module lru_keyed_cache_test;

  localparam int NSLOT       = lkc_pkg::DEPTH_DEF;
  localparam int KW          = lkc_pkg::KEY_WIDTH_DEF;
  localparam int HW          = lkc_pkg::HANDLE_WIDTH_DEF;
  localparam int CAP_W       = lkc_pkg::CAP_W;
  localparam int LEN_W       = lkc_pkg::LEN_W;
  localparam int TYPE_W      = lkc_pkg::TYPE_W;
  localparam int STATUS_W    = lkc_pkg::STATUS_W;
  localparam int COUNT_W     = lkc_pkg::COUNT_W;
  localparam int LATENCY     = 3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 200;

  typedef struct packed {
    logic              op;
    logic [KW-1:0]     key;
    logic [HW-1:0]     handle;
    logic [LEN_W-1:0]  len;
    logic [TYPE_W-1:0] typ;
  } cache_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HW-1:0]       handle;
    logic [LEN_W-1:0]    len;
    logic [TYPE_W-1:0]   typ;
    logic                ev;
    logic [KW-1:0]       ev_key;
    logic [COUNT_W-1:0]  count;
  } cache_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CAP_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic func = lkc_pkg::FUNC_GET;
  logic [KW-1:0] key_tag = '0;
  logic [HW-1:0] content_handle = '0;
  logic [LEN_W-1:0] content_bytes = '0;
  logic [TYPE_W-1:0] content_type_id = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [HW-1:0] out_handle;
  logic [LEN_W-1:0] out_length;
  logic [TYPE_W-1:0] out_type;
  logic evicted;
  logic [KW-1:0] evicted_key;
  logic [COUNT_W-1:0] entry_count;

  // predicted cache contents, slot 0 most recent
  logic [KW-1:0]     lru_key    [NSLOT];
  logic [HW-1:0]     lru_handle [NSLOT];
  logic [LEN_W-1:0]  lru_len    [NSLOT];
  logic [TYPE_W-1:0] lru_type   [NSLOT];
  int                lru_held;
  logic [CAP_W-1:0]  cap_setting;

  cache_rsp_t pending_rsp[$];
  logic [KW-1:0] key_pool[64];
  int pool_size = 1;
  int mismatches = 0;
  int cycle_count = 0;
  int hold_left = 0;
  int stall_left = 0;
  bit src_idle_en = 1'b0;
  bit sink_idle_en = 1'b0;

  lru_keyed_cache dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .key_tag(key_tag), .content_handle(content_handle),
    .content_bytes(content_bytes), .content_type_id(content_type_id),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .out_handle(out_handle), .out_length(out_length),
    .out_type(out_type), .evicted(evicted), .evicted_key(evicted_key),
    .entry_count(entry_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // move slot pos to the front, shifting the more recent ones back
  function automatic void promote_slot(int pos);
    logic [KW-1:0] k;
    logic [HW-1:0] h;
    logic [LEN_W-1:0] l;
    logic [TYPE_W-1:0] t;
    k = lru_key[pos];
    h = lru_handle[pos];
    l = lru_len[pos];
    t = lru_type[pos];
    for (int i = pos; i > 0; i--) begin
      lru_key[i] = lru_key[i-1];
      lru_handle[i] = lru_handle[i-1];
      lru_len[i] = lru_len[i-1];
      lru_type[i] = lru_type[i-1];
    end
    lru_key[0] = k;
    lru_handle[0] = h;
    lru_len[0] = l;
    lru_type[0] = t;
  endfunction

  function automatic cache_rsp_t predict_access(cache_req_t rq);
    cache_rsp_t r;
    int pos;
    int eff_cap;
    r = '0;
    pos = -1;
    for (int i = 0; i < lru_held; i++)
      if (pos < 0 && lru_key[i] == rq.key) pos = i;
    if (rq.op == lkc_pkg::FUNC_GET) begin
      if (pos >= 0) begin
        promote_slot(pos);
        r.status = lkc_pkg::ST_GET_HIT;
        r.handle = lru_handle[0];
        r.len = lru_len[0];
        r.typ = lru_type[0];
      end else begin
        r.status = lkc_pkg::ST_GET_MISS;
      end
    end else if (rq.handle == '0) begin
      r.status = lkc_pkg::ST_PUT_REJECTED;
    end else if (pos >= 0) begin
      promote_slot(pos);
      lru_handle[0] = rq.handle;
      lru_len[0] = rq.len;
      lru_type[0] = rq.typ;
      r.status = lkc_pkg::ST_PUT_UPDATED;
    end else begin
      eff_cap = (cap_setting == 0) ? 1 : (cap_setting > NSLOT) ? NSLOT : int'(cap_setting);
      if (lru_held >= eff_cap && lru_held > 0) begin
        r.ev = 1'b1;
        r.ev_key = lru_key[lru_held-1];
        lru_held--;
      end
      if (lru_held < NSLOT) begin
        for (int i = lru_held; i > 0; i--) begin
          lru_key[i] = lru_key[i-1];
          lru_handle[i] = lru_handle[i-1];
          lru_len[i] = lru_len[i-1];
          lru_type[i] = lru_type[i-1];
        end
        lru_key[0] = rq.key;
        lru_handle[0] = rq.handle;
        lru_len[0] = rq.len;
        lru_type[0] = rq.typ;
        lru_held++;
      end
      r.status = lkc_pkg::ST_PUT_INSERTED;
    end
    r.count = COUNT_W'(lru_held);
    return r;
  endfunction

  task automatic note_mismatch(string field, logic [31:0] exp_v, logic [31:0] got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch at %0t: %s expected %0h got %0h", $realtime, field, exp_v, got_v);
  endtask

  // result checker
  always @(posedge clk) begin
    cache_rsp_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_rsp.size() == 0) begin
        note_mismatch("unexpected transaction", 32'd0, 32'(status));
      end else begin
        e = pending_rsp.pop_front();
        if (status !== e.status)
          note_mismatch("status", 32'(e.status), 32'(status));
        if (out_handle !== e.handle)
          note_mismatch("out_handle", 32'(e.handle), 32'(out_handle));
        if (out_length !== e.len)
          note_mismatch("out_length", 32'(e.len), 32'(out_length));
        if (out_type !== e.typ)
          note_mismatch("out_type", 32'(e.typ), 32'(out_type));
        if (evicted !== e.ev)
          note_mismatch("evicted", 32'(e.ev), 32'(evicted));
        if (evicted_key !== e.ev_key)
          note_mismatch("evicted_key", 32'(e.ev_key), 32'(evicted_key));
        if (entry_count !== e.count)
          note_mismatch("entry_count", 32'(e.count), 32'(entry_count));
      end
    end
  end

  // receiver stall: long hold-off first, then random bursts
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
      out_stall = 1'b1;
      stall_left = $urandom_range(0, 5);
    end else begin
      out_stall = 1'b0;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // called just after a falling edge; returns just after a falling edge
  task automatic send_req(cache_req_t rq);
    if (src_idle_en && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 6)) @(negedge clk);
    func = rq.op;
    key_tag = rq.key;
    content_handle = rq.handle;
    content_bytes = rq.len;
    content_type_id = rq.typ;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    pending_rsp.push_back(predict_access(rq));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_op(logic op, logic [KW-1:0] k, logic [HW-1:0] h,
                         logic [LEN_W-1:0] l, logic [TYPE_W-1:0] t);
    cache_req_t rq;
    rq = '{op: op, key: k, handle: h, len: l, typ: t};
    send_req(rq);
  endtask

  task automatic wait_cache_idle();
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] v);
    wait_cache_idle();
    cfg_wr_en = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    cap_setting = v;
    lru_held = 0;
  endtask

  task automatic fill_key_pool(int n);
    pool_size = n;
    for (int i = 0; i < n; i++) key_pool[i] = $urandom;
  endtask

  task automatic send_random();
    cache_req_t rq;
    rq.op = $urandom_range(0, 1) ? lkc_pkg::FUNC_PUT : lkc_pkg::FUNC_GET;
    rq.key = ($urandom_range(0, 15) == 0) ? KW'($urandom)
                                          : key_pool[$urandom_range(0, pool_size-1)];
    rq.handle = ($urandom_range(0, 11) == 0) ? '0 : HW'($urandom);
    rq.len = LEN_W'($urandom);
    rq.typ = TYPE_W'($urandom);
    send_req(rq);
  endtask

  task automatic test_directed_basics();
    send_op(lkc_pkg::FUNC_GET, 32'h0, 32'h0, '0, '0);
    send_op(lkc_pkg::FUNC_PUT, 32'h0, 32'h1, '0, '0);
    send_op(lkc_pkg::FUNC_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, '1);
    send_op(lkc_pkg::FUNC_GET, 32'h0, 32'h0, '0, '0);
    send_op(lkc_pkg::FUNC_GET, 32'hFFFF_FFFF, 32'h0, '0, '0);
    send_op(lkc_pkg::FUNC_PUT, 32'h1234_5678, 32'h0, 20'h12345, 8'h5A);
    send_op(lkc_pkg::FUNC_PUT, 32'h0, 32'hA5A5_5A5A, 20'hABCDE, 8'hC3);
    send_op(lkc_pkg::FUNC_GET, 32'h0, 32'h0, '0, '0);
    send_op(lkc_pkg::FUNC_GET, 32'h1234_5678, 32'h0, '0, '0);
    send_op(lkc_pkg::FUNC_PUT, 32'h0, 32'h0, 20'h1, 8'h1);
    send_op(lkc_pkg::FUNC_GET, 32'h0, 32'h0, '0, '0);
  endtask

  task automatic test_capacity_one();
    set_capacity(CAP_W'(1));
    send_op(lkc_pkg::FUNC_PUT, 32'hAAAA_0001, 32'h11, 20'h10, 8'h01);
    send_op(lkc_pkg::FUNC_PUT, 32'h5555_0002, 32'h22, 20'h20, 8'h02);
    send_op(lkc_pkg::FUNC_GET, 32'hAAAA_0001, 32'h0, '0, '0);
    send_op(lkc_pkg::FUNC_GET, 32'h5555_0002, 32'h0, '0, '0);
    send_op(lkc_pkg::FUNC_PUT, 32'h5555_0002, 32'h33, 20'h30, 8'h03);
  endtask

  task automatic test_capacity_zero();
    set_capacity(CAP_W'(0));
    send_op(lkc_pkg::FUNC_PUT, 32'h0000_0010, 32'h44, 20'h40, 8'h04);
    send_op(lkc_pkg::FUNC_PUT, 32'h0000_0020, 32'h55, 20'h50, 8'h05);
    send_op(lkc_pkg::FUNC_GET, 32'h0000_0020, 32'h0, '0, '0);
  endtask

  task automatic test_random_mix();
    int caps[6] = '{16, 31, 4, 2, 0, 0};
    caps[5] = $urandom_range(1, 15);
    for (int p = 0; p < 6; p++) begin
      set_capacity(CAP_W'(caps[p]));
      fill_key_pool((caps[p] == 0 ? 1 : caps[p] > NSLOT ? NSLOT : caps[p]) + 1 + p % 4 * 2);
      src_idle_en = (p != 2);
      sink_idle_en = (p != 3);
      repeat (90) send_random();
    end
  endtask

  task automatic test_backpressure();
    set_capacity(CAP_W'(8));
    fill_key_pool(12);
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    @(negedge clk);
    repeat (20) send_random();
    wait_cache_idle();
    sink_idle_en = 1'b1;
    repeat (20) send_random();
  endtask

  task automatic test_no_idle();
    set_capacity(CAP_W'(3));
    fill_key_pool(6);
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    repeat (80) send_random();
  endtask

  initial begin
    lru_held = 0;
    cap_setting = lkc_pkg::CAP_RESET;
    repeat (8) @(negedge clk);
    rst = 1'b0;
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
    test_directed_basics();
    test_capacity_one();
    test_capacity_zero();
    test_random_mix();
    test_backpressure();
    test_no_idle();
    wait_cache_idle();
    repeat (10) @(negedge clk);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== lru_keyed_cache.f =====
sv/lkc_pkg.sv
sv/lkc_cell.sv
sv/lru_keyed_cache.sv
sv/lkc_checker.sv
bench/lru_keyed_cache_test.sv
